[hdl/rdc_pkg.sv]
// rdc_pkg: shared types, constants and the digit-to-ascii mapping
// for the radix digit converter; no dependencies
package rdc_pkg;

    localparam int RADIX_W = 5;
    localparam int DIGIT_W = 4;
    localparam int CHAR_W  = 7;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    localparam logic [RADIX_W-1:0] RADIX_RESET   = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN     = 5'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX     = 5'd16;
    localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT = 4'd10;
    localparam logic [CHAR_W-1:0]  ASCII_ZERO    = 7'h30;
    localparam logic [CHAR_W-1:0]  ASCII_A       = 7'h41;

    // register index of the radix register
    localparam logic REG_RADIX = 1'b0;

    typedef enum logic [3:0] {
        ST_IDLE    = 4'b0001,
        ST_DIVIDE  = 4'b0010,
        ST_POP_RD  = 4'b0100,
        ST_POP_OUT = 4'b1000
    } conv_state_t;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d < DECIMAL_LIMIT)
        begin
            c = ASCII_ZERO + {3'b000, d};
        end
        else
        begin
            c = ASCII_A + {3'b000, d - DECIMAL_LIMIT};
        end
        return c;
    endfunction

    function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] e;
        if (r < RADIX_MIN)
        begin
            e = RADIX_MIN;
        end
        else if (r > RADIX_MAX)
        begin
            e = RADIX_MAX;
        end
        else
        begin
            e = r;
        end
        return e;
    endfunction

endpackage

[hdl/radix_digit_converter_unit.sv]
// radix_digit_converter_unit: top level of the radix digit converter
// uses rdc_pkg, rdc_divider and rdc_ram
//
// usage: write the radix register (apb, byte address 0, 5 bits, reset 10,
// values outside 2 to 16 used as 2 or 16) while the block is idle. a
// transaction is taken when start is high and busy is low; value is then
// split into digits of the radix, which come out most significant first,
// one per digit_valid pulse, as ascii on digit_char. last_digit marks the
// least significant digit. a value of zero gives no output and busy stays low.
// each digit is worked out by the bit-serial divider and pushed onto the
// digit stack ram; the digits are then popped from it, each by a read and
// a register-out step.
// one transaction at a time; busy drops as the last digit is presented.
// digits beyond DIGIT_DEPTH (more significant ones) are dropped.
// reset clears the control state and sets radix to 10; the receiver
// cannot stall, each digit is shown for exactly one cycle.
module radix_digit_converter_unit
    import rdc_pkg::*;
#(
    parameter int DIGIT_DEPTH = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [VALUE_WIDTH-1:0] value,
    output logic                   digit_valid,
    output logic [CHAR_W-1:0]      digit_char,
    output logic                   last_digit,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_AW-1:0]      paddr,
    input  logic [APB_DW-1:0]      pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    localparam int AW = $clog2(DIGIT_DEPTH);
    localparam int NW = $clog2(DIGIT_DEPTH + 1);

    conv_state_t            state_reg, state_next;
    logic [NW-1:0]          count_reg, count_next;
    logic [RADIX_W-1:0]     radix_reg;
    logic                   strobe_reg, strobe_next;
    logic [CHAR_W-1:0]      char_reg, char_next;
    logic                   last_reg, last_next;

    logic                   div_start;
    logic [VALUE_WIDTH-1:0] div_dividend;
    logic                   div_done;
    logic [VALUE_WIDTH-1:0] div_quotient;
    logic [DIGIT_W-1:0]     div_remainder;

    logic                   ram_we;
    logic [AW-1:0]          ram_raddr;
    logic [DIGIT_W-1:0]     ram_rdata;
    logic                   cfg_write;
    logic                   stack_room;

    // apb register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_RADIX);
    assign prdata    = (paddr[2] == REG_RADIX) ? {{(APB_DW-RADIX_W){1'b0}}, radix_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= RADIX_RESET;
        end
        else if (cfg_write)
        begin
            radix_reg <= pwdata[RADIX_W-1:0];
        end
    end

    rdc_divider #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (clamp_radix(radix_reg)),
        .done     (div_done),
        .quotient (div_quotient),
        .remainder(div_remainder)
    );

    rdc_ram #(
        .WIDTH(DIGIT_W),
        .DEPTH(DIGIT_DEPTH)
    ) u_stack (
        .clk  (clk),
        .we   (ram_we),
        .waddr(count_reg[AW-1:0]),
        .wdata(div_remainder),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign stack_room = (count_reg < NW'(DIGIT_DEPTH));
    assign busy       = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        strobe_next  = 1'b0;
        char_next    = char_reg;
        last_next    = last_reg;
        div_start    = 1'b0;
        div_dividend = div_quotient;
        ram_we       = 1'b0;
        ram_raddr    = count_reg[AW-1:0] - 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                div_dividend = value;
                if (start && (value != '0))
                begin
                    div_start  = 1'b1;
                    count_next = '0;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    if (stack_room)
                    begin
                        ram_we     = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    if (div_quotient != '0)
                    begin
                        div_start = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_POP_RD;
                    end
                end
            end
            ST_POP_RD:
            begin
                count_next = count_reg - 1'b1;
                state_next = ST_POP_OUT;
            end
            ST_POP_OUT:
            begin
                strobe_next = 1'b1;
                char_next   = digit_to_ascii(ram_rdata);
                last_next   = (count_reg == '0);
                state_next  = (count_reg == '0) ? ST_IDLE : ST_POP_RD;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign digit_valid = strobe_reg;
    assign digit_char  = char_reg;
    assign last_digit  = last_reg;

endmodule

[hdl/rdc_ram.sv]
// rdc_ram: generic single-port-write, single-port-read ram with registered read
// no dependencies
module rdc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/rdc_divider.sv]
// rdc_divider: bit-serial restoring divider, one quotient bit per cycle
// divides a VALUE_WIDTH dividend by a radix of 2 to 16; uses rdc_pkg
module rdc_divider
    import rdc_pkg::*;
#(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic [VALUE_WIDTH-1:0] dividend,
    input  logic [RADIX_W-1:0]     divisor,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] quotient,
    output logic [DIGIT_W-1:0]     remainder
);

    localparam int CW = $clog2(VALUE_WIDTH);

    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [DIGIT_W-1:0]     rem_reg, rem_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [RADIX_W-1:0]     rem_shift;
    logic [RADIX_W-1:0]     rem_diff;
    logic                   fits;

    assign rem_shift = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign fits      = (rem_shift >= divisor);
    assign rem_diff  = rem_shift - divisor;

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CW'(VALUE_WIDTH - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[VALUE_WIDTH-2:0], fits};
            rem_next = fits ? rem_diff[DIGIT_W-1:0] : rem_shift[DIGIT_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[verif/tb_radix_digit_converter_unit.sv]
// testbench for radix_digit_converter_unit: directed and random values through
// several radix settings, digits checked against a built-in predictor
// depends on rdc_pkg and the converter rtl only
`timescale 1ns / 100ps

module tb_radix_digit_converter_unit;
    import rdc_pkg::*;

    localparam int DIGIT_DEPTH   = 32;
    localparam int VALUE_WIDTH   = 32;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 64;
    localparam int STALL_LIMIT   = 8000;
    localparam int RANDOM_ITEMS  = 480;
    localparam int REPORT_LIMIT  = 10;

    localparam logic [APB_AW-1:0] ADDR_RADIX = APB_AW'(REG_RADIX) << 2;
    localparam logic [APB_AW-1:0] ADDR_SPARE = APB_AW'(4);

    typedef enum logic [1:0] {
        OP_CONVERT,
        OP_REG_WRITE,
        OP_SETTLE
    } stim_kind_t;

    typedef struct {
        stim_kind_t        kind;
        logic [31:0]       data;
        logic [APB_AW-1:0] addr;
        int                gap;
    } stim_t;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } digit_t;

    typedef enum logic [2:0] {
        DRV_IDLE,
        DRV_GAP,
        DRV_START,
        DRV_SETTLE,
        DRV_SETUP,
        DRV_ACCESS
    } drv_state_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic [VALUE_WIDTH-1:0] value = '0;
    logic                   digit_valid;
    logic [CHAR_W-1:0]      digit_char;
    logic                   last_digit;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [APB_AW-1:0]      paddr = '0;
    logic [APB_DW-1:0]      pwdata = '0;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;

    stim_t      stim_q[$];
    digit_t     digits_due[$];
    stim_t      cur;
    drv_state_t drv_state = DRV_IDLE;
    int         gap_left = 0;
    int         settle_cnt = 0;
    int         mismatches = 0;
    int         idle_cycles = 0;

    logic [RADIX_W-1:0]     radix_cfg = RADIX_RESET;
    logic                   nx_start;
    logic [VALUE_WIDTH-1:0] nx_value;
    logic                   nx_psel;
    logic                   nx_penable;
    logic                   nx_pwrite;
    logic [APB_AW-1:0]      nx_paddr;
    logic [APB_DW-1:0]      nx_pwdata;

    radix_digit_converter_unit #(
        .DIGIT_DEPTH(DIGIT_DEPTH),
        .VALUE_WIDTH(VALUE_WIDTH)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .value(value),
        .digit_valid(digit_valid),
        .digit_char(digit_char),
        .last_digit(last_digit),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always #1 clk = ~clk;

    function automatic logic [31:0] base_of(input logic [RADIX_W-1:0] r);
        return (r < RADIX_MIN) ? 32'(RADIX_MIN) : (r > RADIX_MAX) ? 32'(RADIX_MAX) : 32'(r);
    endfunction

    // divide down, then queue the digits most significant first
    function automatic void predict_digits(input logic [31:0] v, input logic [RADIX_W-1:0] r);
        logic [3:0]  held [DIGIT_DEPTH];
        logic [31:0] q;
        logic [31:0] b;
        digit_t      e;
        int          n;
        int          i;
        b = base_of(r);
        q = v;
        n = 0;
        while (q != 0)
        begin
            if (n < DIGIT_DEPTH)
            begin
                held[n] = 4'(q % b);
                n++;
            end
            q = q / b;
        end
        for (i = n - 1; i >= 0; i--)
        begin
            if (held[i] < DECIMAL_LIMIT)
            begin
                e.ch = ASCII_ZERO + CHAR_W'(held[i]);
            end
            else
            begin
                e.ch = ASCII_A + CHAR_W'(held[i] - DECIMAL_LIMIT);
            end
            e.last = (i == 0);
            digits_due.push_back(e);
        end
    endfunction

    task automatic take_next();
        if (stim_q.size() == 0)
        begin
            nx_start = 1'b0;
            drv_state = DRV_IDLE;
        end
        else
        begin
            cur = stim_q.pop_front();
            if (cur.kind != OP_CONVERT)
            begin
                nx_start = 1'b0;
                settle_cnt = 0;
                drv_state = DRV_SETTLE;
            end
            else if (cur.gap == 0)
            begin
                nx_start = 1'b1;
                nx_value = cur.data;
                drv_state = DRV_START;
            end
            else
            begin
                nx_start = 1'b0;
                gap_left = cur.gap;
                drv_state = DRV_GAP;
            end
        end
    endtask

    // driver: conversion transactions and register writes
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drv_state = DRV_IDLE;
            start <= 1'b0;
            value <= '0;
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
            paddr <= '0;
            pwdata <= '0;
        end
        else
        begin
            nx_start = start;
            nx_value = value;
            nx_psel = psel;
            nx_penable = penable;
            nx_pwrite = pwrite;
            nx_paddr = paddr;
            nx_pwdata = pwdata;
            case (drv_state)
                DRV_IDLE:
                begin
                    take_next();
                end
                DRV_GAP:
                begin
                    if (gap_left <= 1)
                    begin
                        nx_start = 1'b1;
                        nx_value = cur.data;
                        drv_state = DRV_START;
                    end
                    else
                    begin
                        gap_left--;
                    end
                end
                DRV_START:
                begin
                    if (start && !busy)
                    begin
                        predict_digits(value, radix_cfg);
                        take_next();
                    end
                end
                DRV_SETTLE:
                begin
                    if (digits_due.size() == 0 && !busy)
                    begin
                        settle_cnt++;
                    end
                    else
                    begin
                        settle_cnt = 0;
                    end
                    if (settle_cnt >= SETTLE_CYCLES)
                    begin
                        if (cur.kind == OP_REG_WRITE)
                        begin
                            nx_psel = 1'b1;
                            nx_pwrite = 1'b1;
                            nx_penable = 1'b0;
                            nx_paddr = cur.addr;
                            nx_pwdata = cur.data;
                            drv_state = DRV_SETUP;
                        end
                        else
                        begin
                            take_next();
                        end
                    end
                end
                DRV_SETUP:
                begin
                    nx_penable = 1'b1;
                    drv_state = DRV_ACCESS;
                end
                DRV_ACCESS:
                begin
                    if (psel && penable && pwrite && pready)
                    begin
                        if (paddr[APB_AW-1:2] == REG_RADIX)
                        begin
                            radix_cfg = pwdata[RADIX_W-1:0];
                        end
                        nx_psel = 1'b0;
                        nx_penable = 1'b0;
                        nx_pwrite = 1'b0;
                        take_next();
                    end
                end
                default:
                begin
                    drv_state = DRV_IDLE;
                end
            endcase
            start <= nx_start;
            value <= nx_value;
            psel <= nx_psel;
            penable <= nx_penable;
            pwrite <= nx_pwrite;
            paddr <= nx_paddr;
            pwdata <= nx_pwdata;
        end
    end

    task automatic flag_mismatch(input string what, input digit_t e);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
        begin
            $display("digit mismatch (%s): expected char %h last %b, got char %h last %b",
                     what, e.ch, e.last, digit_char, last_digit);
        end
    endtask

    // monitor: each digit against the oldest expected one
    always @(posedge clk)
    begin : check_digits
        digit_t e;
        if (rst_n && digit_valid)
        begin
            if (digits_due.size() == 0)
            begin
                e.ch = '0;
                e.last = 1'b0;
                flag_mismatch("no digit expected", e);
            end
            else
            begin
                e = digits_due.pop_front();
                if (digit_char !== e.ch || last_digit !== e.last)
                begin
                    flag_mismatch("wrong digit", e);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || digit_valid || (psel && penable && pwrite))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
                $display("tb_radix_digit_converter_unit: errors");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic add_convert(input logic [31:0] v, input int g);
        stim_t s;
        s.kind = OP_CONVERT;
        s.data = v;
        s.addr = '0;
        s.gap = g;
        stim_q.push_back(s);
    endtask

    task automatic add_write(input logic [APB_AW-1:0] a, input logic [RADIX_W-1:0] r);
        stim_t s;
        s.kind = OP_REG_WRITE;
        s.data = ($urandom() & ~32'h1F) | 32'(r);
        s.addr = a;
        s.gap = 0;
        stim_q.push_back(s);
    endtask

    task automatic add_settle();
        stim_t s;
        s.kind = OP_SETTLE;
        s.data = '0;
        s.addr = '0;
        s.gap = 0;
        stim_q.push_back(s);
    endtask

    function automatic logic [31:0] pick_value(input logic [RADIX_W-1:0] r);
        longint unsigned p;
        logic [31:0]     b;
        int              k;
        b = base_of(r);
        case ($urandom_range(0, 9))
            0:
            begin
                return '0;
            end
            1, 2:
            begin
                return $urandom_range(1, 300);
            end
            3:
            begin
                return 32'hFFFF_FFFF - $urandom_range(0, 3);
            end
            4, 5:
            begin
                // powers of the radix and one below them
                p = 1;
                k = $urandom_range(1, 32);
                repeat (k)
                begin
                    if (p * b <= 64'hFFFF_FFFF)
                    begin
                        p = p * b;
                    end
                end
                return 32'(p - $urandom_range(0, 1));
            end
            default:
            begin
                return $urandom();
            end
        endcase
    endfunction

    function automatic int pick_gap(input bit calm);
        int sel;
        sel = $urandom_range(0, 99);
        if (calm || sel < 60)
        begin
            return 0;
        end
        else if (sel < 90)
        begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(20, 300);
    endfunction

    initial
    begin : stimulus
        logic [RADIX_W-1:0] r;
        bit                 calm;
        int                 n;
        int                 ph;
        int                 cnt;

        // reset radix first, then the clamping extremes
        add_convert(32'd0, 0);
        add_convert(32'd1, 0);
        add_convert(32'd9, 2);
        add_convert(32'd10, 0);
        add_convert(32'd1234567890, 0);
        add_convert(32'hFFFF_FFFF, 1);
        add_write(ADDR_RADIX, RADIX_MIN);
        add_convert(32'hFFFF_FFFF, 0);
        add_convert(32'h8000_0000, 0);
        add_convert(32'd1, 0);
        add_convert(32'h5555_5555, 3);
        add_write(ADDR_RADIX, RADIX_MAX);
        add_convert(32'hFEDC_BA98, 0);
        add_convert(32'h0123_4567, 0);
        add_convert(32'hABCD_EF0F, 0);
        add_write(ADDR_RADIX, '0);
        add_convert(32'd6, 0);
        add_write(ADDR_RADIX, RADIX_W'(1));
        add_convert(32'hAAAA_AAAA, 0);
        add_write(ADDR_RADIX, RADIX_MAX + RADIX_W'(1));
        add_convert(32'hDEAD_BEEF, 0);
        add_write(ADDR_RADIX, '1);
        add_convert(32'h1234_5678, 0);
        add_write(ADDR_RADIX, RADIX_W'(3));
        add_convert(32'hFFFF_FFFF, 0);
        // write outside the register map leaves the radix alone
        add_write(ADDR_SPARE, RADIX_W'(7));
        add_convert(32'd100, 0);
        add_settle();
        add_convert(32'd0, 0);

        n = 0;
        ph = 0;
        while (n < RANDOM_ITEMS)
        begin
            case (ph % 8)
                0: r = RADIX_MIN;
                1: r = RADIX_MAX;
                2: r = '0;
                3: r = '1;
                4: r = RADIX_RESET;
                default: r = RADIX_W'($urandom_range(0, 31));
            endcase
            add_write(ADDR_RADIX, r);
            if (ph % 5 == 4)
            begin
                add_write(ADDR_SPARE, RADIX_W'($urandom()));
            end
            calm = ($urandom_range(0, 3) == 0);
            cnt = $urandom_range(15, 40);
            repeat (cnt)
            begin
                if ($urandom_range(0, 29) == 0)
                begin
                    add_settle();
                end
                add_convert(pick_value(r), pick_gap(calm));
                n++;
            end
            ph++;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        while (!(stim_q.size() == 0 && drv_state == DRV_IDLE && digits_due.size() == 0
                 && !busy))
        begin
            @(posedge clk);
        end
        repeat (TAIL_CYCLES) @(posedge clk);

        if (digits_due.size() != 0)
        begin
            $display("%0d expected digits never arrived", digits_due.size());
            mismatches += digits_due.size();
        end
        if (mismatches == 0)
        begin
            $display("tb_radix_digit_converter_unit: clean");
        end
        else
        begin
            $display("tb_radix_digit_converter_unit: errors");
        end
        $finish;
    end

endmodule

[radix_digit_converter_unit.f]
hdl/rdc_pkg.sv
hdl/rdc_ram.sv
hdl/rdc_divider.sv
hdl/radix_digit_converter_unit.sv
verif/tb_radix_digit_converter_unit.sv
